### sv/tla_pkg.sv
// Shared types and constants of the terminal line assembler.
`default_nettype none

package tla_pkg;

	localparam int IDX_W = 6;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [1:0] KIND_ECHO    = 2'd0;
	localparam logic [1:0] KIND_CHAR    = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;
	localparam logic [1:0] KIND_DISCARD = 2'd3;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [7:0]       wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} ram_req_t;

endpackage

`default_nettype wire

### sv/tla_line_ram.sv
// Line buffer memory with one write port and one registered read port.
`default_nettype none

module tla_line_ram #(
	parameter int DEPTH = 48
) (
	input  wire logic              clk,
	input  wire tla_pkg::ram_req_t req,
	output logic [7:0]             rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### sv/tla_ctrl.sv
// Byte decoder, result sequencer and output register of the line assembler.
`default_nettype none

module tla_ctrl #(
	parameter int MAX_LINE = 48
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic                        cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  rx_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       kind,
	output logic [7:0]                       out_byte,
	output logic [tla_pkg::IDX_W-1:0]        line_length,
	output logic                             last,
	output tla_pkg::ram_req_t                ram_req,
	input  wire logic [7:0]                  ram_rd_data
);

	localparam logic [tla_pkg::IDX_W-1:0] MAX_CNT = tla_pkg::IDX_W'(MAX_LINE);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ECHO = 6'b000010,
		ST_END  = 6'b000100,
		ST_RD   = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_MARK = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		ECHO_CHAR  = 2'd0,
		ECHO_ERASE = 2'd1,
		ECHO_EOL   = 2'd2
	} echo_prog_t;

	state_t                        state_q, state_d;
	echo_prog_t                    prog_q, prog_d;
	logic [1:0]                    step_q, step_d;
	logic [7:0]                    char_q, char_d;
	logic [tla_pkg::IDX_W-1:0]     count_q, count_d;
	logic [tla_pkg::IDX_W-1:0]     rd_idx_q, rd_idx_d;
	logic                          ovf_q, ovf_d;
	logic                          swallow_q, swallow_d;
	logic                          echo_en_q;

	logic                          out_valid_q;
	logic [1:0]                    kind_q;
	logic [7:0]                    byte_q;
	logic [tla_pkg::IDX_W-1:0]     len_q;
	logic                          last_q;

	logic                          out_free;
	logic                          emit;
	logic [1:0]                    emit_kind;
	logic [7:0]                    emit_byte;
	logic [tla_pkg::IDX_W-1:0]     emit_len;
	logic                          emit_last;

	logic is_cr, is_lf, is_erase, is_print;

	assign is_cr    = (rx_byte == tla_pkg::CH_CR);
	assign is_lf    = (rx_byte == tla_pkg::CH_LF);
	assign is_erase = (rx_byte == tla_pkg::CH_BS) || (rx_byte == tla_pkg::CH_DEL);
	assign is_print = (rx_byte == tla_pkg::CH_TAB) ||
		((rx_byte >= tla_pkg::CH_SPACE) && (rx_byte <= tla_pkg::CH_TILDE));

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		prog_d    = prog_q;
		step_d    = step_q;
		char_d    = char_q;
		count_d   = count_q;
		rd_idx_d  = rd_idx_q;
		ovf_d     = ovf_q;
		swallow_d = swallow_q;
		emit      = 1'b0;
		emit_kind = tla_pkg::KIND_ECHO;
		emit_byte = '0;
		emit_len  = '0;
		emit_last = 1'b0;
		ram_req   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (is_cr || (is_lf && !swallow_q)) begin
						swallow_d = is_cr;
						step_d    = 2'd0;
						prog_d    = ECHO_EOL;
						state_d   = echo_en_q ? ST_ECHO : ST_END;
					end else if (is_lf) begin
						swallow_d = 1'b0;
					end else begin
						swallow_d = 1'b0;
						if (is_erase) begin
							if (count_q != '0) begin
								count_d = count_q - 1'b1;
								prog_d  = ECHO_ERASE;
								step_d  = 2'd0;
								if (echo_en_q) begin
									state_d = ST_ECHO;
								end
							end
						end else if (is_print) begin
							char_d = rx_byte;
							prog_d = ECHO_CHAR;
							step_d = 2'd0;
							if (echo_en_q) begin
								state_d = ST_ECHO;
							end
							if (count_q >= MAX_CNT) begin
								ovf_d = 1'b1;
							end else begin
								ram_req.wr_en   = 1'b1;
								ram_req.wr_addr = count_q;
								ram_req.wr_data = rx_byte;
								count_d         = count_q + 1'b1;
							end
						end
					end
				end
			end
			ST_ECHO: begin
				if (out_free) begin
					emit = 1'b1;
					unique case (prog_q)
						ECHO_CHAR: begin
							emit_byte = char_q;
							emit_last = 1'b1;
							state_d   = ST_IDLE;
						end
						ECHO_ERASE: begin
							emit_byte = (step_q == 2'd1) ? tla_pkg::CH_SPACE : tla_pkg::CH_BS;
							if (step_q == 2'd2) begin
								emit_last = 1'b1;
								state_d   = ST_IDLE;
							end else begin
								step_d = step_q + 2'd1;
							end
						end
						ECHO_EOL: begin
							if (step_q == 2'd0) begin
								emit_byte = tla_pkg::CH_CR;
								step_d    = 2'd1;
							end else begin
								emit_byte = tla_pkg::CH_LF;
								emit_last = !ovf_q && (count_q == '0);
								state_d   = ST_END;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_END: begin
				if (ovf_q) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_kind = tla_pkg::KIND_DISCARD;
						emit_last = 1'b1;
						count_d   = '0;
						ovf_d     = 1'b0;
						state_d   = ST_IDLE;
					end
				end else if (count_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					rd_idx_d = '0;
					state_d  = ST_RD;
				end
			end
			ST_RD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = rd_idx_q;
				state_d         = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = tla_pkg::KIND_CHAR;
					emit_byte = ram_rd_data;
					if ((rd_idx_q + 1'b1) == count_q) begin
						state_d = ST_MARK;
					end else begin
						rd_idx_d = rd_idx_q + 1'b1;
						state_d  = ST_RD;
					end
				end
			end
			ST_MARK: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = tla_pkg::KIND_END;
					emit_len  = count_q;
					emit_last = 1'b1;
					count_d   = '0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			swallow_q   <= 1'b0;
			echo_en_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			ovf_q     <= ovf_d;
			swallow_q <= swallow_d;
			if (cfg_wr_en) begin
				echo_en_q <= cfg_wr_data;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		prog_q   <= prog_d;
		step_q   <= step_d;
		char_q   <= char_d;
		rd_idx_q <= rd_idx_d;
		if (emit) begin
			kind_q <= emit_kind;
			byte_q <= emit_byte;
			len_q  <= emit_len;
			last_q <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_byte    = byte_q;
	assign line_length = len_q;
	assign last        = last_q;

endmodule

`default_nettype wire

### sv/terminal_line_assembler_top.sv
// Top level of the terminal line assembler.
// Usage: terminal bytes enter on rx_byte with in_valid/in_ready; each accepted
// request yields zero or more results on kind, out_byte, line_length and last
// with out_valid/out_ready, and last marks the final result of a byte.
// With echo on, a printable byte taken in the idle state is echoed through the
// echo state and the output register, and an erase of a stored character gives
// three echo results on consecutive cycles while the receiver is ready.
// A line end gives two echo results when echo is on, then a buffer read and an
// output per stored character and one end marker for a non-empty line, or a
// discard marker if it overflowed; the sequencer waits for each read before the next.
// The input is ready only while no results of the previous byte are pending. A
// result waiting in the output register does not block the next byte when the
// previous byte is finished; otherwise the sequencer holds while the receiver
// stalls and resumes without losing or repeating a result. Reset empties the
// line, clears the overflow and LF swallow marks and turns echo on; the buffer
// contents need no clearing. The echo enable register is written via cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle (not enforced).
`default_nettype none

module terminal_line_assembler_top #(
	parameter int MAX_LINE = 48
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       out_byte,
	output logic [5:0]       line_length,
	output logic             last
);

	tla_pkg::ram_req_t ram_req;
	logic [7:0]        ram_rd_data;

	tla_ctrl #(
		.MAX_LINE(MAX_LINE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.out_byte    (out_byte),
		.line_length (line_length),
		.last        (last),
		.ram_req     (ram_req),
		.ram_rd_data (ram_rd_data)
	);

	tla_line_ram #(
		.DEPTH(MAX_LINE)
	) u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rd_data)
	);

endmodule

`default_nettype wire

### sv/tla_checker.sv
// Port checker of the terminal line assembler and its bind.
`default_nettype none

module tla_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] out_byte,
	input wire logic [5:0] line_length,
	input wire logic       last
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte) &&
			$stable(line_length) && $stable(last))
	else $error("Stalled result changed before it was taken.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tla_pkg::KIND_END) |->
			last && (out_byte == 8'd0) && (line_length != 6'd0))
	else $error("End marker is malformed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tla_pkg::KIND_DISCARD) |->
			last && (out_byte == 8'd0) && (line_length == 6'd0))
	else $error("Discard marker is malformed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tla_pkg::KIND_CHAR) |-> !last && (line_length == 6'd0))
	else $error("Line character is flagged as last or carries a length.");

endmodule

bind terminal_line_assembler_top tla_checker u_tla_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kind        (kind),
	.out_byte    (out_byte),
	.line_length (line_length),
	.last        (last)
);

`default_nettype wire

### bench/tb_terminal_line_assembler_top.sv
// Self-checking testbench for the terminal line assembler: predicted echo and line results.
`default_nettype none

module tb_terminal_line_assembler_top;

	localparam int LINE_CAP = 48;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] chr;
		logic [5:0] len;
		logic       last_flag;
	} line_result_t;

	class line_echo_tracker;
		logic [7:0]   line_buf [LINE_CAP];
		int unsigned  chars_held;
		bit           overflow_mark;
		bit           lf_armed;
		bit           echo_on;
		line_result_t pending_results [$];
		int unsigned  errors;

		function new();
			chars_held = 0;
			overflow_mark = 1'b0;
			lf_armed = 1'b0;
			echo_on = 1'b1;
			errors = 0;
		endfunction

		function void push(input logic [1:0] k, input logic [7:0] c, input logic [5:0] l);
			line_result_t r;
			r.kind = k;
			r.chr = c;
			r.len = l;
			r.last_flag = 1'b0;
			pending_results.push_back(r);
		endfunction

		function void close_line();
			if (echo_on) begin
				push(tla_pkg::KIND_ECHO, tla_pkg::CH_CR, 6'd0);
				push(tla_pkg::KIND_ECHO, tla_pkg::CH_LF, 6'd0);
			end
			if (overflow_mark) begin
				push(tla_pkg::KIND_DISCARD, 8'd0, 6'd0);
			end else if (chars_held > 0) begin
				for (int i = 0; i < chars_held; i++)
					push(tla_pkg::KIND_CHAR, line_buf[i], 6'd0);
				push(tla_pkg::KIND_END, 8'd0, 6'(chars_held));
			end
			chars_held = 0;
			overflow_mark = 1'b0;
		endfunction

		function void take_rx_byte(input logic [7:0] b);
			int queued_at_entry;
			queued_at_entry = pending_results.size();
			if (b == tla_pkg::CH_CR) begin
				lf_armed = 1'b1;
				close_line();
			end else if (b == tla_pkg::CH_LF) begin
				if (lf_armed)
					lf_armed = 1'b0;
				else
					close_line();
			end else begin
				lf_armed = 1'b0;
				if (b == tla_pkg::CH_BS || b == tla_pkg::CH_DEL) begin
					if (chars_held > 0) begin
						chars_held--;
						if (echo_on) begin
							push(tla_pkg::KIND_ECHO, tla_pkg::CH_BS, 6'd0);
							push(tla_pkg::KIND_ECHO, tla_pkg::CH_SPACE, 6'd0);
							push(tla_pkg::KIND_ECHO, tla_pkg::CH_BS, 6'd0);
						end
					end
				end else if (b == tla_pkg::CH_TAB ||
						(b >= tla_pkg::CH_SPACE && b <= tla_pkg::CH_TILDE)) begin
					if (echo_on)
						push(tla_pkg::KIND_ECHO, b, 6'd0);
					if (chars_held >= LINE_CAP) begin
						overflow_mark = 1'b1;
					end else begin
						line_buf[chars_held] = b;
						chars_held++;
					end
				end
			end
			if (pending_results.size() > queued_at_entry)
				pending_results[pending_results.size() - 1].last_flag = 1'b1;
		endfunction

		function void match_result(input logic [1:0] k, input logic [7:0] c,
				input logic [5:0] l, input logic lf);
			line_result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d out_byte %0h line_length %0d last %0d",
					k, c, l, lf);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (k !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, k);
				errors++;
			end
			if (c !== want.chr) begin
				$error("out_byte: expected %0h, actual %0h", want.chr, c);
				errors++;
			end
			if (l !== want.len) begin
				$error("line_length: expected %0d, actual %0d", want.len, l);
				errors++;
			end
			if (lf !== want.last_flag) begin
				$error("last: expected %0d, actual %0d", want.last_flag, lf);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic       cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [5:0] line_length;
	logic       last;

	line_echo_tracker board;
	int unsigned      send_gap = 0;
	int unsigned      stall_pct = 0;
	int unsigned      hold_left = 0;
	int unsigned      items_sent = 0;

	terminal_line_assembler_top #(.MAX_LINE(LINE_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_byte(out_byte),
		.line_length(line_length),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// The receiver stalls at random, or holds off completely while hold_left counts down.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.match_result(kind, out_byte, line_length, last);
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		board.take_rx_byte(b);
		items_sent++;
	endtask

	task automatic write_echo(input bit v);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.echo_on = v;
	endtask

	function automatic logic [7:0] pick_printable();
		if ($urandom_range(0, 99) < 6)
			return tla_pkg::CH_TAB;
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] pick_ignored();
		logic [7:0] b;
		if ($urandom_range(0, 1) == 1)
			return 8'($urandom_range(128, 255));
		do
			b = 8'($urandom_range(0, 31));
		while (b == tla_pkg::CH_BS || b == tla_pkg::CH_TAB || b == tla_pkg::CH_LF ||
			b == tla_pkg::CH_CR);
		return b;
	endfunction

	task automatic send_line(input int n_chars, input int erase_pct, input int tail_erases);
		int unsigned pick;
		for (int i = 0; i < n_chars; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < erase_pct)
				send_byte($urandom_range(0, 1) ? tla_pkg::CH_BS : tla_pkg::CH_DEL);
			else if (pick < erase_pct + 4)
				send_byte(pick_ignored());
			else
				send_byte(pick_printable());
		end
		repeat (tail_erases)
			send_byte($urandom_range(0, 1) ? tla_pkg::CH_BS : tla_pkg::CH_DEL);
		case ($urandom_range(0, 2))
			0: send_byte(tla_pkg::CH_CR);
			1: begin
				send_byte(tla_pkg::CH_CR);
				send_byte(tla_pkg::CH_LF);
			end
			default: send_byte(tla_pkg::CH_LF);
		endcase
	endtask

	task automatic run_phase(input bit echo, input int gap, input int stall, input int hold,
			input int forced_len, input int forced_tail);
		int unsigned start;
		write_echo(echo);
		send_gap = gap;
		stall_pct = stall;
		hold_left = hold;
		if (forced_len > 0)
			send_line(forced_len, 0, forced_tail);
		start = items_sent;
		while (items_sent - start < 10) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 5))
					send_byte(8'($urandom_range(0, 255)));
			end else if ($urandom_range(0, 99) < 6) begin
				send_line($urandom_range(40, 55), 10, 0);
			end else begin
				send_line($urandom_range(0, 9), 10, 0);
			end
		end
	endtask

	initial begin
		logic [7:0] opening [$];
		logic [7:0] quiet [$];
		opening = {tla_pkg::CH_LF, tla_pkg::CH_BS, 8'h00, 8'h80, 8'hFF, tla_pkg::CH_SPACE,
			tla_pkg::CH_TILDE, tla_pkg::CH_TAB, 8'h41, tla_pkg::CH_DEL, tla_pkg::CH_BS,
			tla_pkg::CH_CR, tla_pkg::CH_LF, tla_pkg::CH_CR, 8'h1B, tla_pkg::CH_LF, 8'h61,
			tla_pkg::CH_LF, tla_pkg::CH_LF};
		quiet = {8'h62, tla_pkg::CH_DEL, 8'h63, tla_pkg::CH_CR, tla_pkg::CH_CR,
			tla_pkg::CH_LF};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_byte(opening[i]);
		write_echo(1'b0);
		foreach (quiet[i])
			send_byte(quiet[i]);

		run_phase(1'b1, 0, 0, 0, LINE_CAP, 0);
		run_phase(1'b0, 82, 0, 0, LINE_CAP + 4, 3);
		run_phase(1'b1, 0, 82, 0, 0, 0);
		run_phase(1'b0, 14, 14, 0, 0, 0);
		run_phase(1'b1, 0, 0, 400, LINE_CAP, 0);

		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (2 * LINE_CAP + 8) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
sv/tla_pkg.sv
sv/tla_line_ram.sv
sv/tla_ctrl.sv
sv/terminal_line_assembler_top.sv
sv/tla_checker.sv
bench/tb_terminal_line_assembler_top.sv
